// ===== hw/rtl/bsr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared types, header positions and helpers for the BMP byte stream decoder.
// ----------------------------------------------------------------------------
package bsr_pkg;

   localparam int QDepth   = 4;
   localparam int QIdxBits = $clog2(QDepth);
   localparam int QCntBits = $clog2(QDepth + 1);

   localparam logic [31:0] POS_OFFSET_B0   = 32'd10;
   localparam logic [31:0] POS_OFFSET_B1   = 32'd11;
   localparam logic [31:0] POS_OFFSET_B2   = 32'd12;
   localparam logic [31:0] POS_OFFSET_B3   = 32'd13;
   localparam logic [31:0] POS_WIDTH_LO    = 32'd18;
   localparam logic [31:0] POS_WIDTH_HI    = 32'd19;
   localparam logic [31:0] POS_HEIGHT_LO   = 32'd22;
   localparam logic [31:0] POS_HEIGHT_HI   = 32'd23;
   localparam logic [31:0] POS_DEPTH       = 32'd28;
   localparam logic [31:0] POS_COMPRESSION = 32'd30;
   localparam logic [31:0] MIN_DATA_OFFSET = 32'd31;

   localparam logic [7:0] DEPTH_16     = 8'd16;
   localparam logic [7:0] DEPTH_24     = 8'd24;
   localparam logic [7:0] DEPTH_32     = 8'd32;
   localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

   typedef enum logic [1:0] {
      FMT_555,
      FMT_RGB,
      FMT_RGBA,
      FMT_ERR
   } fmt_type;

   typedef enum logic [1:0] {
      ST_PIXEL          = 2'd0,
      ST_NO_COMPRESSION = 2'd1,
      ST_BAD_DEPTH      = 2'd2,
      ST_BAD_OFFSET     = 2'd3
   } status_type;

   typedef struct packed {
      fmt_type     fmt;
      logic [31:0] word;
      status_type  status;
      logic        last;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_flags_type;

   // floor(x * 8.23) for a 5-bit channel
   function automatic logic [7:0] scale5(input logic [4:0] x);
      logic [7:0] r;
      case (x)
         5'd0:  r = 8'd0;
         5'd1:  r = 8'd8;
         5'd2:  r = 8'd16;
         5'd3:  r = 8'd24;
         5'd4:  r = 8'd32;
         5'd5:  r = 8'd41;
         5'd6:  r = 8'd49;
         5'd7:  r = 8'd57;
         5'd8:  r = 8'd65;
         5'd9:  r = 8'd74;
         5'd10: r = 8'd82;
         5'd11: r = 8'd90;
         5'd12: r = 8'd98;
         5'd13: r = 8'd106;
         5'd14: r = 8'd115;
         5'd15: r = 8'd123;
         5'd16: r = 8'd131;
         5'd17: r = 8'd139;
         5'd18: r = 8'd148;
         5'd19: r = 8'd156;
         5'd20: r = 8'd164;
         5'd21: r = 8'd172;
         5'd22: r = 8'd181;
         5'd23: r = 8'd189;
         5'd24: r = 8'd197;
         5'd25: r = 8'd205;
         5'd26: r = 8'd213;
         5'd27: r = 8'd222;
         5'd28: r = 8'd230;
         5'd29: r = 8'd238;
         5'd30: r = 8'd246;
         default: r = 8'd255;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bmp_stream_to_rgba_top.sv =====
`default_nettype none
// A pixel or header error item passes through the queue and then the output register after its last byte is accepted.
// Throughput: one file byte per cycle while the queue is not full.
// A four-entry queue lets bytes keep flowing while rsp_ready is low, until it fills.
// Reset: synchronous, active high; parser back to the header, queue and output emptied.
// ----------------------------------------------------------------------------
// bmp_stream_to_rgba_top
// Uncompressed BMP byte stream to RGBA pixel decoder.
// ----------------------------------------------------------------------------
module bmp_stream_to_rgba_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_file_byte,
   input  wire logic       req_start_of_file,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_red,
   output logic [7:0]      rsp_green,
   output logic [7:0]      rsp_blue,
   output logic [7:0]      rsp_alpha,
   output logic [1:0]      rsp_status,
   output logic            rsp_last_pixel
);

   bsr_pkg::q_flags_type q_flags;
   bsr_pkg::entry_type   push_entry;
   bsr_pkg::entry_type   head;
   logic                 push;
   logic                 pop;

   assign req_ready = !q_flags.full;

   bsr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_byte    (req_file_byte),
      .in_sof     (req_start_of_file),
      .q_flags    (q_flags),
      .push       (push),
      .push_entry (push_entry)
   );

   bsr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .flags      (q_flags)
   );

   bsr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_flags    (q_flags),
      .pop        (pop),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_red    (rsp_red),
      .out_green  (rsp_green),
      .out_blue   (rsp_blue),
      .out_alpha  (rsp_alpha),
      .out_status (rsp_status),
      .out_last   (rsp_last_pixel)
   );

   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      !(push && q_flags.full))
      else $error("item pushed into a full queue");

   a_no_pop_when_empty : assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_flags.empty)
      else $error("item popped from an empty queue");

   a_error_item_clear : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != bsr_pkg::ST_PIXEL) |->
         (rsp_red == 8'd0 && rsp_green == 8'd0 && rsp_blue == 8'd0 &&
          rsp_alpha == 8'd0 && !rsp_last_pixel))
      else $error("error item carries pixel data");

   a_reset_empties : assert property (@(posedge clock)
      reset |=> (!rsp_valid && q_flags.empty))
      else $error("reset left items in flight");

endmodule
`default_nettype wire

// ===== hw/rtl/bsr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsr_front
// Header parser and pixel byte gatherer; pushes one entry per pixel or error.
// ----------------------------------------------------------------------------
module bsr_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire logic [7:0]          in_byte,
   input  wire logic                in_sof,
   input  wire bsr_pkg::q_flags_type q_flags,
   output logic                     push,
   output bsr_pkg::entry_type       push_entry
);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_SKIP,
      PH_PIXEL,
      PH_PAD,
      PH_DONE
   } phase_type;

   logic [31:0] pos_ff, pos_in;
   logic [31:0] off_ff, off_in;
   logic [15:0] wid_ff, wid_in;
   logic [15:0] hgt_ff, hgt_in;
   logic [7:0]  dep_ff, dep_in;
   logic [15:0] row_ff, row_in;
   logic [15:0] col_ff, col_in;
   logic [1:0]  bip_ff, bip_in;
   logic [1:0]  pad_ff, pad_in;
   logic [23:0] pix_ff, pix_in;
   phase_type   phase_ff, phase_in;

   logic accept;

   assign accept = in_valid && !q_flags.full;

   always_comb begin
      logic [31:0] pos_v;
      logic [31:0] off_v;
      logic [15:0] wid_v;
      logic [15:0] hgt_v;
      logic [7:0]  dep_v;
      logic [15:0] row_v;
      logic [15:0] col_v;
      logic [1:0]  bip_v;
      logic [1:0]  pad_v;
      logic [23:0] pix_v;
      phase_type   phase_v;
      logic        do_pix;
      logic [2:0]  need_v;
      logic [1:0]  pad_new;
      bsr_pkg::status_type st;

      pos_in     = pos_ff;
      off_in     = off_ff;
      wid_in     = wid_ff;
      hgt_in     = hgt_ff;
      dep_in     = dep_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      bip_in     = bip_ff;
      pad_in     = pad_ff;
      pix_in     = pix_ff;
      phase_in   = phase_ff;
      push       = 1'b0;
      push_entry = '0;
      do_pix     = 1'b0;
      need_v     = 3'd4;
      pad_new    = 2'd0;
      st         = bsr_pkg::ST_PIXEL;

      // start of file restarts from the reset picture
      pos_v   = in_sof ? '0 : pos_ff;
      off_v   = in_sof ? '0 : off_ff;
      wid_v   = in_sof ? '0 : wid_ff;
      hgt_v   = in_sof ? '0 : hgt_ff;
      dep_v   = in_sof ? '0 : dep_ff;
      row_v   = in_sof ? '0 : row_ff;
      col_v   = in_sof ? '0 : col_ff;
      bip_v   = in_sof ? '0 : bip_ff;
      pad_v   = in_sof ? '0 : pad_ff;
      pix_v   = in_sof ? '0 : pix_ff;
      phase_v = in_sof ? PH_HEADER : phase_ff;

      if (accept) begin
         pos_in   = (pos_v == '1) ? pos_v : pos_v + 32'd1;
         off_in   = off_v;
         wid_in   = wid_v;
         hgt_in   = hgt_v;
         dep_in   = dep_v;
         row_in   = row_v;
         col_in   = col_v;
         bip_in   = bip_v;
         pad_in   = pad_v;
         pix_in   = pix_v;
         phase_in = phase_v;

         unique case (phase_v)
            PH_HEADER: begin
               if (pos_v == bsr_pkg::POS_OFFSET_B0) off_in[7:0]   = in_byte;
               if (pos_v == bsr_pkg::POS_OFFSET_B1) off_in[15:8]  = in_byte;
               if (pos_v == bsr_pkg::POS_OFFSET_B2) off_in[23:16] = in_byte;
               if (pos_v == bsr_pkg::POS_OFFSET_B3) off_in[31:24] = in_byte;
               if (pos_v == bsr_pkg::POS_WIDTH_LO)  wid_in[7:0]   = in_byte;
               if (pos_v == bsr_pkg::POS_WIDTH_HI)  wid_in[15:8]  = in_byte;
               if (pos_v == bsr_pkg::POS_HEIGHT_LO) hgt_in[7:0]   = in_byte;
               if (pos_v == bsr_pkg::POS_HEIGHT_HI) hgt_in[15:8]  = in_byte;
               if (pos_v == bsr_pkg::POS_DEPTH)     dep_in        = in_byte;
               if (pos_v == bsr_pkg::POS_COMPRESSION) begin
                  if (in_byte != 8'd0) begin
                     st = bsr_pkg::ST_NO_COMPRESSION;
                  end else if (dep_v != bsr_pkg::DEPTH_16 && dep_v != bsr_pkg::DEPTH_24 &&
                               dep_v != bsr_pkg::DEPTH_32) begin
                     st = bsr_pkg::ST_BAD_DEPTH;
                  end else if (off_v < bsr_pkg::MIN_DATA_OFFSET) begin
                     st = bsr_pkg::ST_BAD_OFFSET;
                  end
                  if (st != bsr_pkg::ST_PIXEL) begin
                     phase_in          = PH_DONE;
                     push              = 1'b1;
                     push_entry.fmt    = bsr_pkg::FMT_ERR;
                     push_entry.status = st;
                  end else if (wid_v == 16'd0 || hgt_v == 16'd0) begin
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               if (pos_v >= off_v) begin
                  phase_in = PH_PIXEL;
                  do_pix   = 1'b1;
               end
            end
            PH_PIXEL: begin
               do_pix = 1'b1;
            end
            PH_PAD: begin
               pad_in = pad_v - 2'd1;
               if (pad_v == 2'd1) phase_in = PH_PIXEL;
            end
            PH_DONE: begin
            end
            default: begin
            end
         endcase

         if (do_pix) begin
            if (dep_v == bsr_pkg::DEPTH_16) need_v = 3'd2;
            else if (dep_v == bsr_pkg::DEPTH_24) need_v = 3'd3;
            if ({1'b0, bip_v} + 3'd1 < need_v) begin
               case (bip_v)
                  2'd0:    pix_in[7:0]   = in_byte;
                  2'd1:    pix_in[15:8]  = in_byte;
                  default: pix_in[23:16] = in_byte;
               endcase
               bip_in = bip_v + 2'd1;
            end else begin
               push              = 1'b1;
               push_entry.status = bsr_pkg::ST_PIXEL;
               if (dep_v == bsr_pkg::DEPTH_16) begin
                  push_entry.fmt  = bsr_pkg::FMT_555;
                  push_entry.word = {16'd0, in_byte, pix_v[7:0]};
               end else if (dep_v == bsr_pkg::DEPTH_24) begin
                  push_entry.fmt  = bsr_pkg::FMT_RGB;
                  push_entry.word = {in_byte, pix_v};
               end else begin
                  push_entry.fmt  = bsr_pkg::FMT_RGBA;
                  push_entry.word = {in_byte, pix_v};
               end
               bip_in = 2'd0;
               pix_in = '0;
               if ({1'b0, col_v} + 17'd1 >= {1'b0, wid_v}) begin
                  col_in = '0;
                  if ({1'b0, row_v} + 17'd1 >= {1'b0, hgt_v}) begin
                     push_entry.last = 1'b1;
                     phase_in        = PH_DONE;
                  end else begin
                     row_in = row_v + 16'd1;
                     // rows pad to four bytes
                     if (dep_v == bsr_pkg::DEPTH_16) pad_new = {wid_v[0], 1'b0};
                     else if (dep_v == bsr_pkg::DEPTH_24) pad_new = wid_v[1:0];
                     pad_in   = pad_new;
                     phase_in = (pad_new != 2'd0) ? PH_PAD : PH_PIXEL;
                  end
               end else begin
                  col_in = col_v + 16'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         off_ff   <= '0;
         wid_ff   <= '0;
         hgt_ff   <= '0;
         dep_ff   <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         bip_ff   <= '0;
         pad_ff   <= '0;
         pix_ff   <= '0;
         phase_ff <= PH_HEADER;
      end else begin
         pos_ff   <= pos_in;
         off_ff   <= off_in;
         wid_ff   <= wid_in;
         hgt_ff   <= hgt_in;
         dep_ff   <= dep_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         bip_ff   <= bip_in;
         pad_ff   <= pad_in;
         pix_ff   <= pix_in;
         phase_ff <= phase_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/bsr_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsr_queue
// Short register queue between the parser and the pixel formatter.
// ----------------------------------------------------------------------------
module bsr_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire bsr_pkg::entry_type  push_entry,
   input  wire logic                pop,
   output bsr_pkg::entry_type       head,
   output bsr_pkg::q_flags_type     flags
);

   bsr_pkg::entry_type              mem_ff [bsr_pkg::QDepth];
   logic [bsr_pkg::QIdxBits-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [bsr_pkg::QIdxBits-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [bsr_pkg::QCntBits-1:0]    count_ff, count_in;
   logic                            do_push;
   logic                            do_pop;

   assign flags.full  = (count_ff == bsr_pkg::QCntBits'(bsr_pkg::QDepth));
   assign flags.empty = (count_ff == '0);
   assign do_push     = push && !flags.full;
   assign do_pop      = pop && !flags.empty;
   assign head        = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + bsr_pkg::QIdxBits'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + bsr_pkg::QIdxBits'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + bsr_pkg::QCntBits'(1);
      if (!do_push && do_pop) count_in = count_ff - bsr_pkg::QCntBits'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_entry;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/bsr_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsr_back
// Pixel formatter: expands queued entries into RGBA items with an output register.
// ----------------------------------------------------------------------------
module bsr_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bsr_pkg::entry_type   head,
   input  wire bsr_pkg::q_flags_type q_flags,
   output logic                      pop,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic [7:0]                out_red,
   output logic [7:0]                out_green,
   output logic [7:0]                out_blue,
   output logic [7:0]                out_alpha,
   output logic [1:0]                out_status,
   output logic                      out_last
);

   logic       valid_ff, valid_in;
   logic [7:0] red_ff, red_in;
   logic [7:0] green_ff, green_in;
   logic [7:0] blue_ff, blue_in;
   logic [7:0] alpha_ff, alpha_in;
   logic [1:0] status_ff, status_in;
   logic       last_ff, last_in;

   assign pop = !q_flags.empty && (!valid_ff || out_ready);

   always_comb begin
      valid_in  = valid_ff && !out_ready;
      red_in    = red_ff;
      green_in  = green_ff;
      blue_in   = blue_ff;
      alpha_in  = alpha_ff;
      status_in = status_ff;
      last_in   = last_ff;
      if (pop) begin
         valid_in  = 1'b1;
         status_in = head.status;
         last_in   = head.last;
         unique case (head.fmt)
            bsr_pkg::FMT_555: begin
               blue_in  = bsr_pkg::scale5(head.word[4:0]);
               green_in = bsr_pkg::scale5({head.word[9:8], head.word[7:5]});
               red_in   = bsr_pkg::scale5(head.word[14:10]);
               alpha_in = bsr_pkg::ALPHA_OPAQUE;
            end
            bsr_pkg::FMT_RGB: begin
               blue_in  = head.word[7:0];
               green_in = head.word[15:8];
               red_in   = head.word[31:24];
               alpha_in = bsr_pkg::ALPHA_OPAQUE;
            end
            bsr_pkg::FMT_RGBA: begin
               blue_in  = head.word[7:0];
               green_in = head.word[15:8];
               red_in   = head.word[23:16];
               alpha_in = head.word[31:24];
            end
            default: begin
               blue_in  = '0;
               green_in = '0;
               red_in   = '0;
               alpha_in = '0;
               last_in  = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      red_ff    <= red_in;
      green_ff  <= green_in;
      blue_ff   <= blue_in;
      alpha_ff  <= alpha_in;
      status_ff <= status_in;
      last_ff   <= last_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_red    = red_ff;
   assign out_green  = green_ff;
   assign out_blue   = blue_ff;
   assign out_alpha  = alpha_ff;
   assign out_status = status_ff;
   assign out_last   = last_ff;

endmodule
`default_nettype wire
